// File: hdl/phc_pkg.sv
// Shared types and constants for the packet header classifier.
// Used by phc_capture, phc_classify and packet_header_classifier; no dependencies.
package phc_pkg;

  typedef logic [5:0] phc_class_t;

  // Class codes of the result item.
  localparam phc_class_t CLS_OTHER    = 6'd0;
  localparam phc_class_t CLS_ARP      = 6'd1;
  localparam phc_class_t CLS_IPV4     = 6'd2;
  localparam phc_class_t CLS_IPV6     = 6'd3;
  localparam phc_class_t CLS_ICMP     = 6'd4;
  localparam phc_class_t CLS_ICMPV6   = 6'd5;
  localparam phc_class_t CLS_IGMP     = 6'd6;
  localparam phc_class_t CLS_OSPF     = 6'd7;
  localparam phc_class_t CLS_EIGRP    = 6'd8;
  localparam phc_class_t CLS_TCP      = 6'd9;
  localparam phc_class_t CLS_UDP      = 6'd10;
  localparam phc_class_t CLS_FTP      = 6'd11;
  localparam phc_class_t CLS_SSH      = 6'd12;
  localparam phc_class_t CLS_TELNET   = 6'd13;
  localparam phc_class_t CLS_SMTP     = 6'd14;
  localparam phc_class_t CLS_DNS      = 6'd15;
  localparam phc_class_t CLS_DHCP     = 6'd16;
  localparam phc_class_t CLS_HTTP     = 6'd17;
  localparam phc_class_t CLS_POP3     = 6'd18;
  localparam phc_class_t CLS_BGP      = 6'd19;
  localparam phc_class_t CLS_HTTPS    = 6'd20;
  localparam phc_class_t CLS_KERBEROS = 6'd21;
  localparam phc_class_t CLS_SYSLOG   = 6'd22;
  localparam phc_class_t CLS_RDP      = 6'd23;
  localparam phc_class_t CLS_TFTP     = 6'd24;
  localparam phc_class_t CLS_NTP      = 6'd25;
  localparam phc_class_t CLS_SNMP     = 6'd26;
  localparam phc_class_t CLS_SNMPTRAP = 6'd27;
  localparam phc_class_t CLS_LDAP     = 6'd28;
  localparam phc_class_t CLS_ISAKMP   = 6'd29;
  localparam phc_class_t CLS_RIP      = 6'd30;
  localparam phc_class_t CLS_RADIUS   = 6'd31;
  localparam phc_class_t CLS_L2TP     = 6'd32;
  localparam phc_class_t CLS_NAT_T    = 6'd33;
  localparam phc_class_t CLS_OICQ     = 6'd34;
  localparam phc_class_t CLS_NBNS     = 6'd35;
  localparam phc_class_t CLS_MAX      = CLS_NBNS;

  // EtherTypes.
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86dd;

  // IP protocol and next-header numbers.
  localparam logic [7:0] PROTO_ICMP   = 8'h01;
  localparam logic [7:0] PROTO_IGMP   = 8'h02;
  localparam logic [7:0] PROTO_TCP    = 8'h06;
  localparam logic [7:0] PROTO_UDP    = 8'h11;
  localparam logic [7:0] PROTO_ICMPV6 = 8'h3a;
  localparam logic [7:0] PROTO_EIGRP  = 8'h58;
  localparam logic [7:0] PROTO_OSPF   = 8'h59;

  // Header byte counts a frame must reach.
  localparam logic [6:0] NEED_OTHER  = 7'd14;
  localparam logic [6:0] NEED_ARP    = 7'd42;
  localparam logic [6:0] NEED_IPV4   = 7'd34;
  localparam logic [6:0] NEED_IPV6   = 7'd54;
  localparam logic [6:0] NEED_IPV6L4 = 7'd58;
  localparam logic [6:0] ETH_HDR     = 7'd14;
  localparam logic [6:0] IPV6_L4     = 7'd54;

  // Captured frame state; also the snapshot handed to the classifier.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [5:0]  ip_hdr_bytes;
    logic [7:0]  next_proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } phc_frame_t;

  typedef struct packed {
    phc_class_t  proto_class;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] frame_len;
    logic        truncated;
  } phc_result_t;

endpackage

// File: hdl/packet_header_classifier.sv
// Ethernet frame header classifier: one byte per unstalled cycle in, one result item per frame out.
// The result item is registered in the frame snapshot, then in the output register, where it is valid.
// Throughput: one byte per unstalled cycle, back to back across frames, set by the capture stage.
// The frame snapshot and output register decouple the two channels for stalls.
// Reset clears the byte count, captured fields and both valid flags; no clearing pass.
// Depends on phc_pkg, phc_capture and phc_classify.
module packet_header_classifier import phc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_protocol_class,
  output logic [63:0] out_src_addr_high,
  output logic [63:0] out_src_addr_low,
  output logic [63:0] out_dst_addr_high,
  output logic [63:0] out_dst_addr_low,
  output logic [15:0] out_frame_length,
  output logic        out_truncated
);

  phc_frame_t  frame;
  logic        frame_valid;
  phc_result_t result;
  phc_result_t result_r;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;
  logic        take;

  // The snapshot moves on whenever the output register is empty or being emptied.
  assign take     = frame_valid && (!out_valid_r || !out_stall);
  assign in_stall = frame_valid && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  phc_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .take        (take),
    .frame       (frame),
    .frame_valid (frame_valid)
  );

  phc_classify u_classify (
    .frame  (frame),
    .result (result)
  );

  assign out_valid_nxt = take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_protocol_class = result_r.proto_class;
  assign out_src_addr_high  = result_r.src_hi;
  assign out_src_addr_low   = result_r.src_lo;
  assign out_dst_addr_high  = result_r.dst_hi;
  assign out_dst_addr_low   = result_r.dst_lo;
  assign out_frame_length   = result_r.frame_len;
  assign out_truncated      = result_r.truncated;

`ifndef NO_ASSERTIONS
  a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled while the output register is empty");

  a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_protocol_class <= CLS_MAX))
    else $error("protocol class code out of range");

  a_arp_addr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_protocol_class == CLS_ARP) |->
      (out_src_addr_high == 64'd0 && out_dst_addr_high == 64'd0 &&
       out_src_addr_low[63:32] == 32'd0 && out_dst_addr_low[63:32] == 32'd0))
    else $error("ARP result carries address bits above the IP address");

  a_long_frame_not_truncated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_length >= 16'd78) |-> !out_truncated)
    else $error("frame long enough for every header marked truncated");
`endif

endmodule

// File: hdl/phc_capture.sv
// Byte-position header capture and the frame snapshot register.
// Depends on phc_pkg for the frame state type and EtherType constants.
module phc_capture import phc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,
  output phc_frame_t frame,
  output logic       frame_valid
);

  phc_frame_t state_r, state_nxt;
  phc_frame_t frame_r;
  logic       frame_valid_r, frame_valid_nxt;

  logic [15:0] idx;
  logic [6:0]  l4;
  logic        is_ip;
  logic [1:0]  port_k;

  function automatic logic [63:0] put_byte(input logic [63:0] w, input logic [15:0] pos,
                                           input logic [15:0] i, input logic [7:0] b);
    logic [63:0] r;
    logic [2:0]  lane;
    r    = w;
    lane = 3'(pos - i);
    r[{lane, 3'b000} +: 8] = b;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    idx       = state_r.frame_len;
    l4        = '0;
    is_ip     = 1'b0;
    port_k    = 2'(idx - {9'b0, l4});

    if (idx < 16'd6) begin
      state_nxt.dst_lo = put_byte(state_r.dst_lo, 16'd5, idx, data_byte);
    end else if (idx < 16'd12) begin
      state_nxt.src_lo = put_byte(state_r.src_lo, 16'd11, idx, data_byte);
    end else if (idx == 16'd12) begin
      state_nxt.ether_type = {data_byte, 8'h00};
    end else if (idx == 16'd13) begin
      state_nxt.ether_type = {state_r.ether_type[15:8], data_byte};
      // Known EtherTypes carry IP addresses, so the MAC addresses make way.
      if (state_nxt.ether_type == ETH_ARP || state_nxt.ether_type == ETH_IPV4 ||
          state_nxt.ether_type == ETH_IPV6) begin
        state_nxt.src_hi = '0;
        state_nxt.src_lo = '0;
        state_nxt.dst_hi = '0;
        state_nxt.dst_lo = '0;
      end
    end else if (state_r.ether_type == ETH_ARP) begin
      if (idx >= 16'd28 && idx <= 16'd31)
        state_nxt.src_lo = put_byte(state_r.src_lo, 16'd31, idx, data_byte);
      if (idx >= 16'd38 && idx <= 16'd41)
        state_nxt.dst_lo = put_byte(state_r.dst_lo, 16'd41, idx, data_byte);
    end else if (state_r.ether_type == ETH_IPV4) begin
      if (idx == 16'd14)
        state_nxt.ip_hdr_bytes = {data_byte[3:0], 2'b00};
      if (idx == 16'd23)
        state_nxt.next_proto = data_byte;
      if (idx >= 16'd26 && idx <= 16'd29)
        state_nxt.src_lo = put_byte(state_r.src_lo, 16'd29, idx, data_byte);
      if (idx >= 16'd30 && idx <= 16'd33)
        state_nxt.dst_lo = put_byte(state_r.dst_lo, 16'd33, idx, data_byte);
      // The header length taken from this very byte already counts.
      l4    = ETH_HDR + {1'b0, state_nxt.ip_hdr_bytes};
      is_ip = 1'b1;
    end else if (state_r.ether_type == ETH_IPV6) begin
      if (idx == 16'd20)
        state_nxt.next_proto = data_byte;
      if (idx >= 16'd22 && idx <= 16'd29)
        state_nxt.src_hi = put_byte(state_r.src_hi, 16'd29, idx, data_byte);
      if (idx >= 16'd30 && idx <= 16'd37)
        state_nxt.src_lo = put_byte(state_r.src_lo, 16'd37, idx, data_byte);
      if (idx >= 16'd38 && idx <= 16'd45)
        state_nxt.dst_hi = put_byte(state_r.dst_hi, 16'd45, idx, data_byte);
      if (idx >= 16'd46 && idx <= 16'd53)
        state_nxt.dst_lo = put_byte(state_r.dst_lo, 16'd53, idx, data_byte);
      l4    = IPV6_L4;
      is_ip = 1'b1;
    end

    port_k = 2'(idx - {9'b0, l4});
    if (is_ip && idx >= {9'b0, l4} && idx <= {9'b0, l4} + 16'd3) begin
      case (port_k)
        2'd0:    state_nxt.src_port[15:8] = data_byte;
        2'd1:    state_nxt.src_port[7:0]  = data_byte;
        2'd2:    state_nxt.dst_port[15:8] = data_byte;
        default: state_nxt.dst_port[7:0]  = data_byte;
      endcase
    end

    if (state_r.frame_len != 16'hffff)
      state_nxt.frame_len = state_r.frame_len + 16'd1;

    frame_valid_nxt = (accept && last_byte) || (frame_valid_r && !take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      frame_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          state_r <= '0;
        end else begin
          state_r <= state_nxt;
        end
      end
      frame_valid_r <= frame_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      frame_r <= state_nxt;
    end
  end

  assign frame       = frame_r;
  assign frame_valid = frame_valid_r;

endmodule

// File: hdl/phc_classify.sv
// Protocol classification and truncation check of one captured frame.
// Depends on phc_pkg for the frame and result types and the class codes.
module phc_classify import phc_pkg::*; (
  input  phc_frame_t  frame,
  output phc_result_t result
);

  phc_class_t cls;
  logic [6:0] need;

  function automatic logic port_is(input logic [15:0] sp, input logic [15:0] dp,
                                   input logic [15:0] p);
    return (sp == p) || (dp == p);
  endfunction

  function automatic phc_class_t tcp_class(input logic [15:0] sp, input logic [15:0] dp);
    phc_class_t c;
    if (port_is(sp, dp, 16'd20) || port_is(sp, dp, 16'd21)) c = CLS_FTP;
    else if (port_is(sp, dp, 16'd22))   c = CLS_SSH;
    else if (port_is(sp, dp, 16'd23))   c = CLS_TELNET;
    else if (port_is(sp, dp, 16'd25))   c = CLS_SMTP;
    else if (port_is(sp, dp, 16'd53))   c = CLS_DNS;
    else if (port_is(sp, dp, 16'd68))   c = CLS_DHCP;
    else if (port_is(sp, dp, 16'd80))   c = CLS_HTTP;
    else if (port_is(sp, dp, 16'd110))  c = CLS_POP3;
    else if (port_is(sp, dp, 16'd179))  c = CLS_BGP;
    else if (port_is(sp, dp, 16'd443))  c = CLS_HTTPS;
    else if (port_is(sp, dp, 16'd464))  c = CLS_KERBEROS;
    else if (port_is(sp, dp, 16'd514))  c = CLS_SYSLOG;
    else if (port_is(sp, dp, 16'd3389)) c = CLS_RDP;
    else                                c = CLS_TCP;
    return c;
  endfunction

  function automatic phc_class_t udp_class(input logic [15:0] sp, input logic [15:0] dp);
    phc_class_t c;
    if (port_is(sp, dp, 16'd53))        c = CLS_DNS;
    else if (port_is(sp, dp, 16'd67))   c = CLS_DHCP;
    else if (port_is(sp, dp, 16'd69))   c = CLS_TFTP;
    else if (port_is(sp, dp, 16'd123))  c = CLS_NTP;
    else if (port_is(sp, dp, 16'd161))  c = CLS_SNMP;
    else if (port_is(sp, dp, 16'd162))  c = CLS_SNMPTRAP;
    else if (port_is(sp, dp, 16'd389))  c = CLS_LDAP;
    else if (port_is(sp, dp, 16'd500))  c = CLS_ISAKMP;
    else if (port_is(sp, dp, 16'd520))  c = CLS_RIP;
    else if (port_is(sp, dp, 16'd1812) || port_is(sp, dp, 16'd1813)) c = CLS_RADIUS;
    else if (port_is(sp, dp, 16'd1701)) c = CLS_L2TP;
    else if (port_is(sp, dp, 16'd4500)) c = CLS_NAT_T;
    else if (port_is(sp, dp, 16'd8000)) c = CLS_OICQ;
    else if (port_is(sp, dp, 16'd137))  c = CLS_NBNS;
    else                                c = CLS_UDP;
    return c;
  endfunction

  always_comb begin
    cls  = CLS_OTHER;
    need = NEED_OTHER;
    if (frame.ether_type == ETH_ARP) begin
      cls  = CLS_ARP;
      need = NEED_ARP;
    end else if (frame.ether_type == ETH_IPV4) begin
      need = NEED_IPV4;
      case (frame.next_proto)
        PROTO_IGMP:  cls = CLS_IGMP;
        PROTO_ICMP:  cls = CLS_ICMP;
        PROTO_TCP:   cls = tcp_class(frame.src_port, frame.dst_port);
        PROTO_UDP:   cls = udp_class(frame.src_port, frame.dst_port);
        PROTO_OSPF:  cls = CLS_OSPF;
        PROTO_EIGRP: cls = CLS_EIGRP;
        default:     cls = CLS_IPV4;
      endcase
      // With ports to read, the frame must also reach the end of them.
      if ((frame.next_proto == PROTO_TCP || frame.next_proto == PROTO_UDP) &&
          (ETH_HDR + {1'b0, frame.ip_hdr_bytes} + 7'd4) > NEED_IPV4)
        need = ETH_HDR + {1'b0, frame.ip_hdr_bytes} + 7'd4;
    end else if (frame.ether_type == ETH_IPV6) begin
      need = NEED_IPV6;
      case (frame.next_proto)
        PROTO_ICMPV6: cls = CLS_ICMPV6;
        PROTO_IGMP:   cls = CLS_IGMP;
        PROTO_TCP: begin
          cls  = tcp_class(frame.src_port, frame.dst_port);
          need = NEED_IPV6L4;
        end
        PROTO_UDP: begin
          cls  = udp_class(frame.src_port, frame.dst_port);
          need = NEED_IPV6L4;
        end
        PROTO_OSPF:   cls = CLS_OSPF;
        PROTO_EIGRP:  cls = CLS_EIGRP;
        default:      cls = CLS_IPV6;
      endcase
    end

    result.proto_class = cls;
    result.src_hi      = frame.src_hi;
    result.src_lo      = frame.src_lo;
    result.dst_hi      = frame.dst_hi;
    result.dst_lo      = frame.dst_lo;
    result.frame_len   = frame.frame_len;
    result.truncated   = frame.frame_len < {9'b0, need};
  end

endmodule
